/* hw/rtl/stylus_event_tracker_unit_assert.svh */
// Assertion macros used by the checker file of the stylus event tracker.
`ifndef STYLUS_EVENT_TRACKER_UNIT_ASSERT_SVH
`define STYLUS_EVENT_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SEVT_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SEVT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/sevt_pkg.sv */
// Types, codes and constants of the stylus event tracker.
`default_nettype none

package sevt_pkg;

	localparam int unsigned COEF_W    = 32;
	localparam int unsigned VALUE_W   = 16;
	localparam int unsigned COORD_W   = 11;
	localparam int unsigned IDLE_W    = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned HOLD_W    = 16;
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned PROD_W    = 48;
	localparam int unsigned SUM_W     = 50;

	localparam int unsigned DEF_SCREEN_WIDTH  = 1404;
	localparam int unsigned DEF_SCREEN_HEIGHT = 1872;

	localparam logic [COEF_W-1:0] COEF_ONE      = 32'h0001_0000;
	localparam logic [HOLD_W-1:0] HOLDOFF_RESET = 16'd1000;

	typedef enum logic [1:0] {
		OP_KEY,
		OP_AXIS,
		OP_TICK,
		OP_NONE
	} opcode_t;

	typedef enum logic [1:0] {
		KEY_RUBBER,
		KEY_PEN,
		KEY_TOUCH,
		KEY_OTHER
	} key_code_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_PRESSURE,
		AXIS_OTHER
	} axis_code_t;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_PEN_DOWN,
		KIND_ERASER_DOWN,
		KIND_PEN_MOVE,
		KIND_ERASER_MOVE,
		KIND_PEN_UP,
		KIND_ERASER_UP
	} event_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_XX,
		REG_COEF_XY,
		REG_OFFSET_X,
		REG_COEF_YX,
		REG_COEF_YY,
		REG_OFFSET_Y,
		REG_HOLDOFF_TICKS
	} cfg_reg_t;

	// Load enables of the two stages behind the input register.
	typedef struct packed {
		logic adv_s2;
		logic adv_s3;
	} stage_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/sevt_axis_map.sv */
// One screen axis of the affine calibration: products, sum, clamp and floor.
`default_nettype none

module sevt_axis_map
	import sevt_pkg::*;
#(
	parameter int unsigned SIZE = DEF_SCREEN_WIDTH
) (
	input  wire logic                     clk,
	input  wire stage_ctl_t               ctl,
	input  wire logic signed [COEF_W-1:0] coef_a,
	input  wire logic signed [COEF_W-1:0] coef_b,
	input  wire logic signed [COEF_W-1:0] offset,
	input  wire logic [VALUE_W-1:0]       raw_a,
	input  wire logic [VALUE_W-1:0]       raw_b,
	input  wire logic                     map_en,
	output logic [COORD_W-1:0]            screen
);

	localparam longint TOP_L = (longint'(SIZE) - 64'sd1) * (64'sd1 <<< FRAC_W);
	localparam logic signed [SUM_W-1:0] TOP_Q = SUM_W'(TOP_L);
	localparam logic [COORD_W-1:0] LIMIT = COORD_W'(SIZE - 1);

	logic signed [PROD_W-1:0] prod_a, prod_b;
	logic signed [PROD_W-1:0] prod_a_s2, prod_b_s2;
	logic signed [COEF_W-1:0] offset_s2;
	logic                     en_s2;
	logic signed [SUM_W-1:0]  sum;
	logic [COORD_W-1:0]       screen_nxt;

	// Raw values are unsigned, so they enter the product with a zero sign bit.
	assign prod_a = PROD_W'(coef_a) * PROD_W'($signed({1'b0, raw_a}));
	assign prod_b = PROD_W'(coef_b) * PROD_W'($signed({1'b0, raw_b}));

	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			prod_a_s2 <= prod_a;
			prod_b_s2 <= prod_b;
			offset_s2 <= offset;
			en_s2     <= map_en;
		end
	end

	assign sum = SUM_W'(prod_a_s2) + SUM_W'(prod_b_s2) + SUM_W'(offset_s2);

	always_comb begin
		if (!en_s2 || sum[SUM_W-1]) begin
			screen_nxt = '0;
		end else if (sum > TOP_Q) begin
			screen_nxt = LIMIT;
		end else begin
			screen_nxt = sum[FRAC_W +: COORD_W];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s3) begin
			screen <= screen_nxt;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/stylus_event_tracker_unit.sv */
// Top level of the stylus event tracker: event state, pen-active holdoff and calibration.
`default_nettype none

// The stylus event tracker takes one digitizer event per transfer on the event
// channel (a key event, an absolute-axis event or a one millisecond tick) and
// returns exactly one result per event on the result channel, in order. It keeps
// the tool-near, eraser, touching and stroke-started flags, the last raw x, y and
// pressure, a pen-active level that a one-shot holdoff clears some ticks after the
// tool leaves, and a saturating idle tick counter. While touching, an x or y event
// reports a down (first of a stroke) or move, with the raw position mapped to the
// screen by a Q16.16 affine transform, clamped to the screen and floored.
// Throughput is one event per clock while the result channel is not stalled. An event
// passes three registers: the input register, the stage that registers the four 32x17
// coefficient products, and the result register that holds the summed and clamped
// coordinates and offers the result on the result channel. A result waiting on
// a stalled result channel does not block events already in flight: each stage
// loads as soon as the stage behind it has room, and the event channel stalls only
// once all three registers hold an event. Calibration registers are written through
// the configuration channel, which is always ready; write them only while no event
// is in flight. There is no memory and no clearing pass after reset.
module stylus_event_tracker_unit
	import sevt_pkg::*;
#(
	parameter int unsigned SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int unsigned SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Event channel.
	input  wire logic                 evt_valid,
	output logic                      evt_stall,
	input  wire logic [1:0]           opcode,
	input  wire logic [1:0]           event_code,
	input  wire logic [VALUE_W-1:0]   event_value,
	// Result channel.
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output logic [2:0]                event_kind,
	output logic [COORD_W-1:0]        screen_x,
	output logic [COORD_W-1:0]        screen_y,
	output logic [VALUE_W-1:0]        pressure,
	output logic [VALUE_W-1:0]        raw_x,
	output logic [VALUE_W-1:0]        raw_y,
	output logic                      pen_active,
	output logic                      pen_active_changed,
	output logic [IDLE_W-1:0]         idle_ms,
	// Configuration write channel.
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COEF_W-1:0]    cfg_data
);

	// Calibration and holdoff registers.
	logic signed [COEF_W-1:0] coef_xx_q, coef_xy_q, offset_x_q;
	logic signed [COEF_W-1:0] coef_yx_q, coef_yy_q, offset_y_q;
	logic [HOLD_W-1:0]        holdoff_ticks_q;

	// Tracker state.
	logic                tool_near_q, eraser_near_q, touching_q, started_q, active_q;
	logic [VALUE_W-1:0]  raw_x_q, raw_y_q, pressure_q;
	logic                hold_run_q;
	logic [HOLD_W-1:0]   hold_cnt_q;
	logic [IDLE_W-1:0]   idle_cnt_q;

	// Next values of the tracker state for the event in the input register.
	logic                tool_near_d, eraser_near_d, touching_d, started_d, active_d;
	logic [VALUE_W-1:0]  raw_x_d, raw_y_d, pressure_d;
	logic                hold_run_d;
	logic [HOLD_W-1:0]   hold_cnt_d;
	logic [IDLE_W-1:0]   idle_cnt_d;
	logic                key_near;
	event_kind_t         kind_d;
	logic [VALUE_W-1:0]  rep_x_d, rep_y_d;
	logic                map_en;

	// Pipeline valids and handshake.
	logic       valid_s1, valid_s2, valid_s3;
	logic       ready_s1, ready_s2, ready_s3;
	stage_ctl_t ctl;

	// Input register.
	logic [1:0]         opcode_s1, code_s1;
	logic [VALUE_W-1:0] value_s1;

	// Product stage payload.
	event_kind_t        kind_s2;
	logic [VALUE_W-1:0] rep_x_s2, rep_y_s2, pressure_s2;
	logic               active_s2, changed_s2;
	logic [IDLE_W-1:0]  idle_s2;

	// Result register payload.
	event_kind_t        kind_s3;
	logic [VALUE_W-1:0] rep_x_s3, rep_y_s3, pressure_s3;
	logic               active_s3, changed_s3;
	logic [IDLE_W-1:0]  idle_s3;

	//--------------------------------------------------------------------------
	// Handshake. Each stage loads when it is empty or the stage behind it moves,
	// so bubbles are squeezed out even while the result channel is stalled.
	//--------------------------------------------------------------------------
	assign ready_s3   = !valid_s3 || !res_stall;
	assign ready_s2   = !valid_s2 || ready_s3;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign evt_stall  = !ready_s1;
	assign ctl.adv_s2 = valid_s1 && ready_s2;
	assign ctl.adv_s3 = valid_s2 && ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= evt_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// The input register starts out holding an ignored opcode so that the decode
	// below always sees a known event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opcode_s1 <= OP_NONE;
			code_s1   <= '0;
			value_s1  <= '0;
		end else if (evt_valid && ready_s1) begin
			opcode_s1 <= opcode;
			code_s1   <= event_code;
			value_s1  <= event_value;
		end
	end

	//--------------------------------------------------------------------------
	// Configuration writes. The channel never pushes back; indexes past the
	// holdoff register are dropped.
	//--------------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_xx_q       <= COEF_ONE;
			coef_xy_q       <= '0;
			offset_x_q      <= '0;
			coef_yx_q       <= '0;
			coef_yy_q       <= COEF_ONE;
			offset_y_q      <= '0;
			holdoff_ticks_q <= HOLDOFF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_COEF_XX:       coef_xx_q       <= cfg_data;
				REG_COEF_XY:       coef_xy_q       <= cfg_data;
				REG_OFFSET_X:      offset_x_q      <= cfg_data;
				REG_COEF_YX:       coef_yx_q       <= cfg_data;
				REG_COEF_YY:       coef_yy_q       <= cfg_data;
				REG_OFFSET_Y:      offset_y_q      <= cfg_data;
				REG_HOLDOFF_TICKS: holdoff_ticks_q <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	//--------------------------------------------------------------------------
	// Event decode and state update. The state commits when the event leaves the
	// input register, so every event is applied exactly once.
	//--------------------------------------------------------------------------
	always_comb begin
		tool_near_d   = tool_near_q;
		eraser_near_d = eraser_near_q;
		touching_d    = touching_q;
		started_d     = started_q;
		active_d      = active_q;
		raw_x_d       = raw_x_q;
		raw_y_d       = raw_y_q;
		pressure_d    = pressure_q;
		hold_run_d    = hold_run_q;
		hold_cnt_d    = hold_cnt_q;
		idle_cnt_d    = idle_cnt_q;
		kind_d        = KIND_NONE;
		rep_x_d       = '0;
		rep_y_d       = '0;
		map_en        = 1'b0;
		key_near      = (value_s1 != '0);

		unique case (opcode_t'(opcode_s1))
			OP_KEY: begin
				unique case (key_code_t'(code_s1)) inside
					KEY_RUBBER, KEY_PEN: begin
						if (key_code_t'(code_s1) == KEY_RUBBER) begin
							eraser_near_d = key_near;
						end else begin
							tool_near_d = key_near;
						end
						idle_cnt_d = '0;
						// Arriving tool cancels the holdoff; a leaving tool
						// (re)starts it unless the stylus is still down.
						if (key_near) begin
							hold_run_d = 1'b0;
							active_d   = 1'b1;
						end else if (!touching_q) begin
							hold_run_d = 1'b1;
							hold_cnt_d = holdoff_ticks_q;
						end
					end
					KEY_TOUCH: begin
						idle_cnt_d = '0;
						if (key_near) begin
							touching_d = 1'b1;
							hold_run_d = 1'b0;
							active_d   = 1'b1;
						end else if (touching_q) begin
							touching_d = 1'b0;
							started_d  = 1'b0;
							if (!tool_near_q && !eraser_near_q) begin
								hold_run_d = 1'b1;
								hold_cnt_d = holdoff_ticks_q;
							end
							kind_d = eraser_near_q ? KIND_ERASER_UP : KIND_PEN_UP;
						end
					end
					default: ;
				endcase
			end
			OP_AXIS: begin
				unique case (axis_code_t'(code_s1))
					AXIS_X:        raw_x_d    = value_s1;
					AXIS_Y:        raw_y_d    = value_s1;
					AXIS_PRESSURE: pressure_d = value_s1;
					AXIS_OTHER: ;
				endcase
				// Position updates while touching report a down or a move.
				if (touching_q && (axis_code_t'(code_s1) == AXIS_X ||
						axis_code_t'(code_s1) == AXIS_Y)) begin
					idle_cnt_d = '0;
					map_en     = 1'b1;
					if (!started_q) begin
						kind_d    = eraser_near_q ? KIND_ERASER_DOWN : KIND_PEN_DOWN;
						rep_x_d   = raw_x_d;
						rep_y_d   = raw_y_d;
						started_d = 1'b1;
					end else begin
						kind_d = eraser_near_q ? KIND_ERASER_MOVE : KIND_PEN_MOVE;
					end
				end
			end
			OP_TICK: begin
				if (!(&idle_cnt_q)) begin
					idle_cnt_d = idle_cnt_q + IDLE_W'(1);
				end
				// A holdoff loaded with zero expires on the first tick, like one.
				if (hold_run_q) begin
					if (hold_cnt_q <= HOLD_W'(1)) begin
						hold_cnt_d = '0;
						hold_run_d = 1'b0;
						if (!tool_near_q && !eraser_near_q && !touching_q) begin
							active_d = 1'b0;
						end
					end else begin
						hold_cnt_d = hold_cnt_q - HOLD_W'(1);
					end
				end
			end
			OP_NONE: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tool_near_q   <= 1'b0;
			eraser_near_q <= 1'b0;
			touching_q    <= 1'b0;
			started_q     <= 1'b0;
			active_q      <= 1'b0;
			raw_x_q       <= '0;
			raw_y_q       <= '0;
			pressure_q    <= '0;
			hold_run_q    <= 1'b0;
			hold_cnt_q    <= '0;
			idle_cnt_q    <= '0;
		end else if (ctl.adv_s2) begin
			tool_near_q   <= tool_near_d;
			eraser_near_q <= eraser_near_d;
			touching_q    <= touching_d;
			started_q     <= started_d;
			active_q      <= active_d;
			raw_x_q       <= raw_x_d;
			raw_y_q       <= raw_y_d;
			pressure_q    <= pressure_d;
			hold_run_q    <= hold_run_d;
			hold_cnt_q    <= hold_cnt_d;
			idle_cnt_q    <= idle_cnt_d;
		end
	end

	//--------------------------------------------------------------------------
	// Result payload through the product stage and the result register.
	//--------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			kind_s2     <= kind_d;
			rep_x_s2    <= rep_x_d;
			rep_y_s2    <= rep_y_d;
			pressure_s2 <= pressure_d;
			active_s2   <= active_d;
			changed_s2  <= (active_d != active_q);
			idle_s2     <= idle_cnt_d;
		end
		if (ctl.adv_s3) begin
			kind_s3     <= kind_s2;
			rep_x_s3    <= rep_x_s2;
			rep_y_s3    <= rep_y_s2;
			pressure_s3 <= pressure_s2;
			active_s3   <= active_s2;
			changed_s3  <= changed_s2;
			idle_s3     <= idle_s2;
		end
	end

	// The transform uses the raw position as this event leaves it.
	sevt_axis_map #(
		.SIZE(SCREEN_WIDTH)
	) u_map_x (
		.clk    (clk),
		.ctl    (ctl),
		.coef_a (coef_xx_q),
		.coef_b (coef_xy_q),
		.offset (offset_x_q),
		.raw_a  (raw_x_d),
		.raw_b  (raw_y_d),
		.map_en (map_en),
		.screen (screen_x)
	);

	sevt_axis_map #(
		.SIZE(SCREEN_HEIGHT)
	) u_map_y (
		.clk    (clk),
		.ctl    (ctl),
		.coef_a (coef_yx_q),
		.coef_b (coef_yy_q),
		.offset (offset_y_q),
		.raw_a  (raw_x_d),
		.raw_b  (raw_y_d),
		.map_en (map_en),
		.screen (screen_y)
	);

	assign res_valid          = valid_s3;
	assign event_kind         = kind_s3;
	assign pressure           = pressure_s3;
	assign raw_x              = rep_x_s3;
	assign raw_y              = rep_y_s3;
	assign pen_active         = active_s3;
	assign pen_active_changed = changed_s3;
	assign idle_ms            = idle_s3;

endmodule

`default_nettype wire

/* hw/rtl/sevt_checker.sv */
// Port-level checker of the stylus event tracker and its bind to the top level.
`default_nettype none

`include "stylus_event_tracker_unit_assert.svh"

module sevt_checker
	import sevt_pkg::*;
#(
	parameter int unsigned SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int unsigned SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                res_valid,
	input wire logic                res_stall,
	input wire logic [2:0]          event_kind,
	input wire logic [COORD_W-1:0]  screen_x,
	input wire logic [COORD_W-1:0]  screen_y,
	input wire logic                pen_active,
	input wire logic                pen_active_changed,
	input wire logic [IDLE_W-1:0]   idle_ms
);

	// A stalled result holds until it is taken.
	`SEVT_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall,
		res_valid && $stable(event_kind) && $stable(idle_ms) && $stable(screen_x),
		"result changed while stalled")

	// Down, move and up only happen with the stylus touching, so pen-active is set.
	`SEVT_ASSERT_NOW(a_kind_active, clk, arst_n,
		res_valid && event_kind != KIND_NONE, pen_active,
		"stroke event reported without pen-active")

	// Pen-active only clears on a holdoff expiry, which reports no stroke event.
	`SEVT_ASSERT_NOW(a_clear_on_tick, clk, arst_n,
		res_valid && pen_active_changed && !pen_active, event_kind == KIND_NONE,
		"pen-active cleared on a stroke event")

	// Clamped coordinates stay on the screen when it fits in the output width.
	`SEVT_ASSERT_NOW(a_on_screen, clk, arst_n, res_valid,
		(SCREEN_WIDTH > 2048 || 32'(screen_x) < SCREEN_WIDTH) &&
		(SCREEN_HEIGHT > 2048 || 32'(screen_y) < SCREEN_HEIGHT),
		"screen coordinate beyond the clamp limit")

endmodule

bind stylus_event_tracker_unit sevt_checker #(
	.SCREEN_WIDTH  (SCREEN_WIDTH),
	.SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_sevt_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.res_valid          (res_valid),
	.res_stall          (res_stall),
	.event_kind         (event_kind),
	.screen_x           (screen_x),
	.screen_y           (screen_y),
	.pen_active         (pen_active),
	.pen_active_changed (pen_active_changed),
	.idle_ms            (idle_ms)
);

`default_nettype wire

/* test/stylus_event_tracker_unit_tb.sv */
// Testbench of the stylus event tracker: predicted reports checked against every result transfer.
`timescale 1ns / 100ps

module stylus_event_tracker_unit_tb
	import sevt_pkg::*;
();

	// Cycles without any transfer on any channel before the run is declared hung. The longest
	// correct quiet stretch is the deliberate receiver hold-off.
	localparam int WATCH_LIMIT   = 5000;
	localparam int RANDOM_EVENTS = 350;
	localparam int PRINT_LIMIT   = 40;
	localparam int HOLD_CYCLES   = 200;

	// One expected report of the tracker, field for field as it leaves the result channel.
	typedef struct {
		event_kind_t          kind;
		logic [COORD_W-1:0]   sx;
		logic [COORD_W-1:0]   sy;
		logic [VALUE_W-1:0]   prs;
		logic [VALUE_W-1:0]   rx;
		logic [VALUE_W-1:0]   ry;
		logic                 act;
		logic                 chg;
		logic [IDLE_W-1:0]    idle;
	} tracker_report_t;

	logic                 clk;
	logic                 arst_n;
	logic                 evt_valid;
	logic                 evt_stall;
	logic [1:0]           opcode;
	logic [1:0]           event_code;
	logic [VALUE_W-1:0]   event_value;
	logic                 res_valid;
	logic                 res_stall;
	logic [2:0]           event_kind;
	logic [COORD_W-1:0]   screen_x;
	logic [COORD_W-1:0]   screen_y;
	logic [VALUE_W-1:0]   pressure;
	logic [VALUE_W-1:0]   raw_x;
	logic [VALUE_W-1:0]   raw_y;
	logic                 pen_active;
	logic                 pen_active_changed;
	logic [IDLE_W-1:0]    idle_ms;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_data;

	// Calibration as the tracker should hold it; it follows every accepted register write.
	int                   cal_xx = COEF_ONE;
	int                   cal_xy = 0;
	int                   cal_ox = 0;
	int                   cal_yx = 0;
	int                   cal_yy = COEF_ONE;
	int                   cal_oy = 0;
	logic [HOLD_W-1:0]    cal_hold = HOLDOFF_RESET;

	// Tracking state of the predictor, all clear after reset.
	logic                 st_pen = 1'b0;
	logic                 st_eraser = 1'b0;
	logic                 st_touch = 1'b0;
	logic                 st_stroke = 1'b0;
	logic                 st_active = 1'b0;
	logic [VALUE_W-1:0]   st_raw_x = '0;
	logic [VALUE_W-1:0]   st_raw_y = '0;
	logic [VALUE_W-1:0]   st_prs = '0;
	logic                 st_hold_run = 1'b0;
	logic [HOLD_W-1:0]    st_hold_cnt = '0;
	logic [IDLE_W-1:0]    st_idle = '0;

	tracker_report_t      report_queue[$];

	int                   errors;
	int                   events_sent;
	int                   results_seen;
	int                   downs_seen;
	int                   edges_seen;
	int                   cfg_writes;
	int                   settings_used;
	int                   quiet_cycles;
	int                   rx_hold_left;
	bit                   steady;

	stylus_event_tracker_unit i_dut (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Loads the pen-active holdoff; a load while it runs simply restarts it.
	function automatic void start_holdoff();
		st_hold_run = 1'b1;
		st_hold_cnt = cal_hold;
	endfunction

	// A rubber or pen tool arriving or leaving. Arrival cancels the holdoff and raises
	// pen-active, leaving starts the holdoff unless the stylus is still on the surface.
	function automatic void note_tool(input logic near);
		st_idle = '0;
		if (near) begin
			st_hold_run = 1'b0;
			st_active = 1'b1;
		end else if (!st_touch) begin
			start_holdoff();
		end
	endfunction

	// Maps the last raw position to one screen axis. The Q16.16 sum is exact in 64 bits;
	// below zero gives column 0, above the last pixel gives the last pixel, else floor.
	function automatic logic [COORD_W-1:0] to_screen(input int wx, input int wy, input int off,
			input int unsigned size);
		longint acc;
		longint top;
		acc = longint'(wx) * longint'(st_raw_x) + longint'(wy) * longint'(st_raw_y)
			+ longint'(off);
		top = longint'(size - 1) * 65536;
		if (acc < 0)
			return '0;
		if (acc > top)
			return COORD_W'(size - 1);
		return COORD_W'(acc >>> FRAC_W);
	endfunction

	// Advances the tracking state by one event and returns the report that it causes.
	function automatic tracker_report_t track_event(input opcode_t op, input logic [1:0] code,
			input logic [VALUE_W-1:0] val);
		tracker_report_t r;
		logic            was_active;
		was_active = st_active;
		r.kind = KIND_NONE;
		r.sx = '0;
		r.sy = '0;
		r.rx = '0;
		r.ry = '0;
		case (op)
			OP_KEY: begin
				case (key_code_t'(code))
					KEY_RUBBER: begin
						st_eraser = (val != 0);
						note_tool(st_eraser);
					end
					KEY_PEN: begin
						st_pen = (val != 0);
						note_tool(st_pen);
					end
					KEY_TOUCH: begin
						st_idle = '0;
						if (val != 0) begin
							st_touch = 1'b1;
							st_hold_run = 1'b0;
							st_active = 1'b1;
						end else if (st_touch) begin
							// Lifting the stylus ends the stroke; the holdoff only starts
							// when no tool is near any more.
							st_touch = 1'b0;
							st_stroke = 1'b0;
							if (!st_pen && !st_eraser)
								start_holdoff();
							r.kind = st_eraser ? KIND_ERASER_UP : KIND_PEN_UP;
						end
					end
					default: ;
				endcase
			end
			OP_AXIS: begin
				case (axis_code_t'(code))
					AXIS_X:        st_raw_x = val;
					AXIS_Y:        st_raw_y = val;
					AXIS_PRESSURE: st_prs = val;
					default: ;
				endcase
				if (st_touch && (code == AXIS_X || code == AXIS_Y)) begin
					st_idle = '0;
					r.sx = to_screen(cal_xx, cal_xy, cal_ox, DEF_SCREEN_WIDTH);
					r.sy = to_screen(cal_yx, cal_yy, cal_oy, DEF_SCREEN_HEIGHT);
					if (!st_stroke) begin
						// First position of a stroke goes out as a down with the raw values.
						r.kind = st_eraser ? KIND_ERASER_DOWN : KIND_PEN_DOWN;
						r.rx = st_raw_x;
						r.ry = st_raw_y;
						st_stroke = 1'b1;
					end else begin
						r.kind = st_eraser ? KIND_ERASER_MOVE : KIND_PEN_MOVE;
					end
				end
			end
			OP_TICK: begin
				if (st_idle != '1)
					st_idle = st_idle + 1'b1;
				if (st_hold_run) begin
					// A count of zero expires on the next tick just like a count of one.
					if (st_hold_cnt <= 1) begin
						st_hold_cnt = '0;
						st_hold_run = 1'b0;
						if (!st_pen && !st_eraser && !st_touch)
							st_active = 1'b0;
					end else begin
						st_hold_cnt = st_hold_cnt - 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.prs = st_prs;
		r.act = st_active;
		r.chg = (st_active != was_active);
		r.idle = st_idle;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Length of an idle stretch: mostly short, sometimes medium, rarely long.
	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// Axis values lean toward the ends of the range and toward the screen size.
	function automatic logic [VALUE_W-1:0] pick_axis_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r < 6)
			return VALUE_W'($urandom_range(0, 2047));
		return VALUE_W'($urandom());
	endfunction

	// Sends one event and records the report that the tracker owes for it. The event stays
	// offered, unchanged, until the transfer happens; a random gap may follow.
	task automatic send_event(input opcode_t op, input logic [1:0] code,
			input logic [VALUE_W-1:0] val);
		int pause;
		@(negedge clk);
		evt_valid = 1'b1;
		opcode = op;
		event_code = code;
		event_value = val;
		do @(posedge clk); while (evt_stall);
		report_queue.push_back(track_event(op, code, val));
		events_sent++;
		pause = (steady || $urandom_range(0, 1) == 0) ? 0 : pick_pause();
		if (pause > 0) begin
			@(negedge clk);
			evt_valid = 1'b0;
			repeat (pause - 1) @(negedge clk);
		end
	endtask

	task automatic send_ticks(input int count);
		repeat (count) send_event(OP_TICK, 2'd0, '0);
	endtask

	// Random event of any opcode, code and value, including those that the tracker ignores.
	task automatic send_noise();
		send_event(opcode_t'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
			$urandom_range(0, 1) ? VALUE_W'($urandom()) : VALUE_W'(0));
	endtask

	// Stops offering events and waits until every owed report has come back, so that nothing
	// is left in flight before a register write.
	task automatic drain_reports();
		@(negedge clk);
		evt_valid = 1'b0;
		while (report_queue.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [COEF_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_COEF_XX:       cal_xx = data;
			REG_COEF_XY:       cal_xy = data;
			REG_OFFSET_X:      cal_ox = data;
			REG_COEF_YX:       cal_yx = data;
			REG_COEF_YY:       cal_yy = data;
			REG_OFFSET_Y:      cal_oy = data;
			REG_HOLDOFF_TICKS: cal_hold = data[HOLD_W-1:0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_calibration(input int xx, input int xy, input int ox,
			input int yx, input int yy, input int oy);
		write_reg(REG_COEF_XX, xx);
		write_reg(REG_COEF_XY, xy);
		write_reg(REG_OFFSET_X, ox);
		write_reg(REG_COEF_YX, yx);
		write_reg(REG_COEF_YY, yy);
		write_reg(REG_OFFSET_Y, oy);
		settings_used++;
	endtask

	// A stroke that visits the corners of the raw range, for the calibration limits.
	task automatic corner_stroke();
		send_event(OP_KEY, KEY_PEN, 16'h0001);
		send_event(OP_KEY, KEY_TOUCH, 16'h0001);
		send_event(OP_AXIS, AXIS_X, 16'h0000);
		send_event(OP_AXIS, AXIS_Y, 16'h0000);
		send_event(OP_AXIS, AXIS_X, 16'hFFFF);
		send_event(OP_AXIS, AXIS_Y, 16'hFFFF);
		send_event(OP_AXIS, AXIS_X, 16'h0000);
		send_event(OP_KEY, KEY_TOUCH, 16'h0000);
		send_event(OP_KEY, KEY_PEN, 16'h0000);
	endtask

	// A mostly well-formed stroke with random content: the tool comes near, touches down,
	// moves, lifts and leaves, with ticks around it. Now and then a step is missing or the
	// tool leaves while still touching, which exercises the odd orderings.
	task automatic run_stroke();
		key_code_t tool;
		tool = $urandom_range(0, 1) ? KEY_PEN : KEY_RUBBER;
		if ($urandom_range(0, 9) != 0)
			send_event(OP_KEY, tool, VALUE_W'($urandom_range(1, 65535)));
		send_ticks($urandom_range(0, 2));
		send_event(OP_KEY, KEY_TOUCH, VALUE_W'($urandom_range(1, 65535)));
		repeat ($urandom_range(1, 10))
			send_event(OP_AXIS, 2'($urandom_range(0, 2)), pick_axis_value());
		if ($urandom_range(0, 7) == 0)
			send_event(OP_KEY, tool, '0);
		if ($urandom_range(0, 9) != 0)
			send_event(OP_KEY, KEY_TOUCH, '0);
		send_ticks($urandom_range(0, 3));
		send_event(OP_KEY, tool, '0);
		send_ticks($urandom_range(0, 15));
	endtask

	// Picks a calibration: identity, a realistic scale, swapped axes, a mirror or noise.
	task automatic pick_calibration();
		int jx;
		int jy;
		jx = $urandom_range(0, 200) - 100;
		jy = $urandom_range(0, 200) - 100;
		case ($urandom_range(0, 4))
			0: write_calibration(COEF_ONE, 0, 0, 0, COEF_ONE, 0);
			1: write_calibration(1404 + jx, jy, ($urandom_range(0, 40) - 20) * 65536,
				jx, 1872 + jy, ($urandom_range(0, 40) - 20) * 65536);
			2: write_calibration(jx, 1404 + jy, $urandom_range(0, 65535),
				1872 + jx, jy, $urandom_range(0, 65535));
			3: write_calibration(-1404 - jx, 0, 1404 * 65536, 0, -1872 - jy, 1872 * 65536);
			default: write_calibration($urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom());
		endcase
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset calibration and holdoff, then one of each event: ignored opcodes and codes,
	// a release without a touch, a pen stroke with clamped and in-range positions, an
	// eraser arriving mid-stroke, eraser up and down, a tool leaving while touching, and
	// a pen leaving that starts the holdoff.
	task automatic test_directed();
		send_event(OP_TICK, 2'd0, 16'h0000);
		send_event(OP_NONE, 2'd3, 16'hFFFF);
		send_event(OP_KEY, KEY_OTHER, 16'hFFFF);
		send_event(OP_AXIS, AXIS_OTHER, 16'h5A5A);
		send_event(OP_AXIS, AXIS_PRESSURE, 16'hFFFF);
		send_event(OP_KEY, KEY_TOUCH, 16'h0000);
		send_event(OP_AXIS, AXIS_X, 16'h0000);
		send_event(OP_KEY, KEY_PEN, 16'h0001);
		send_event(OP_KEY, KEY_TOUCH, 16'hFFFF);
		send_event(OP_AXIS, AXIS_X, 16'hFFFF);
		send_event(OP_AXIS, AXIS_Y, 16'h0000);
		send_event(OP_AXIS, AXIS_X, 16'd700);
		send_event(OP_AXIS, AXIS_Y, 16'd1871);
		send_event(OP_AXIS, AXIS_PRESSURE, 16'h0000);
		send_event(OP_KEY, KEY_RUBBER, 16'h8000);
		send_event(OP_AXIS, AXIS_Y, 16'd1872);
		send_event(OP_KEY, KEY_TOUCH, 16'h0000);
		send_event(OP_KEY, KEY_TOUCH, 16'h0001);
		send_event(OP_AXIS, AXIS_X, 16'd1403);
		send_event(OP_KEY, KEY_RUBBER, 16'h0000);
		send_event(OP_KEY, KEY_TOUCH, 16'h0000);
		send_event(OP_KEY, KEY_PEN, 16'h0000);
		send_ticks(2);
		drain_reports();
	endtask

	// Holdoff of zero (with junk in the unused upper data bits), one and three ticks,
	// a tool returning while the holdoff runs, a lift with no tool near, and the largest
	// holdoff left running.
	task automatic test_holdoff();
		write_reg(REG_HOLDOFF_TICKS, 32'hFFFF_0000);
		send_event(OP_KEY, KEY_PEN, 16'h0001);
		send_event(OP_KEY, KEY_PEN, 16'h0000);
		send_ticks(2);
		drain_reports();
		write_reg(REG_HOLDOFF_TICKS, 32'd1);
		send_event(OP_KEY, KEY_RUBBER, 16'h0002);
		send_event(OP_KEY, KEY_RUBBER, 16'h0000);
		send_ticks(2);
		drain_reports();
		write_reg(REG_HOLDOFF_TICKS, 32'd3);
		send_event(OP_KEY, KEY_PEN, 16'h0001);
		send_event(OP_KEY, KEY_PEN, 16'h0000);
		send_ticks(2);
		send_event(OP_KEY, KEY_PEN, 16'h0001);
		send_event(OP_KEY, KEY_PEN, 16'h0000);
		send_ticks(4);
		send_event(OP_KEY, KEY_TOUCH, 16'h0001);
		send_event(OP_KEY, KEY_TOUCH, 16'h0000);
		send_ticks(4);
		drain_reports();
		write_reg(REG_HOLDOFF_TICKS, 32'h0000_FFFF);
		send_event(OP_KEY, KEY_PEN, 16'h0001);
		send_event(OP_KEY, KEY_PEN, 16'h0000);
		send_ticks(5);
		drain_reports();
	endtask

	// Coefficients and offsets at their extremes, and offsets on either side of the last
	// pixel, so that every clamp and the floor at the edge are hit.
	task automatic test_calibration_limits();
		write_calibration(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		corner_stroke();
		drain_reports();
		write_calibration(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		corner_stroke();
		drain_reports();
		write_calibration(0, 0, 1403 * 65536 + 65535, 0, 0, 1871 * 65536 + 65535);
		corner_stroke();
		drain_reports();
		write_calibration(0, 0, 1403 * 65536, 0, 0, 1871 * 65536);
		corner_stroke();
		drain_reports();
		write_calibration(0, 0, 1403 * 65536 - 1, 0, 0, -1);
		corner_stroke();
		drain_reports();
		write_calibration(1404, -1, 32'h0000_FFFF, -1, 1872, 32'h0000_FFFF);
		corner_stroke();
		drain_reports();
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering events
	// back to back, so the pipeline fills and the event channel stalls.
	task automatic test_backpressure();
		@(posedge clk);
		rx_hold_left = HOLD_CYCLES;
		steady = 1'b1;
		run_stroke();
		run_stroke();
		steady = 1'b0;
		drain_reports();
	endtask

	// Phases of random strokes and noise, each under a fresh calibration and holdoff.
	// Some phases run with no idling on either side; some pause the sender mid-phase
	// until every report is back.
	task automatic test_random_traffic();
		int first;
		int hold;
		first = events_sent;
		while (events_sent - first < RANDOM_EVENTS) begin
			pick_calibration();
			case ($urandom_range(0, 9))
				0:       hold = 0;
				1:       hold = $urandom_range(13, 65535);
				default: hold = $urandom_range(1, 12);
			endcase
			write_reg(REG_HOLDOFF_TICKS, ($urandom() & 32'hFFFF_0000) | hold);
			steady = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(3, 8)) begin
				if ($urandom_range(0, 9) < 8)
					run_stroke();
				else
					repeat ($urandom_range(1, 6)) send_noise();
				if ($urandom_range(0, 5) == 0)
					drain_reports();
			end
			steady = 1'b0;
			drain_reports();
		end
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	// The receiver stalls at random, with an occasional long hold-off that a test asks for.
	initial begin
		int stall_run;
		stall_run = 0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				res_stall = 1'b1;
				rx_hold_left--;
			end else if (stall_run > 0) begin
				res_stall = 1'b1;
				stall_run--;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				res_stall = 1'b1;
				stall_run = pick_pause() - 1;
			end else begin
				res_stall = 1'b0;
			end
		end
	end

	task automatic compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= PRINT_LIMIT)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	// Every result transfer is checked against the oldest owed report.
	always @(posedge clk) begin
		tracker_report_t want;
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (report_queue.size() == 0) begin
				errors++;
				if (errors <= PRINT_LIMIT)
					$display("%0t: result transfer with no report expected, kind %0d",
						$time, event_kind);
			end else begin
				want = report_queue.pop_front();
				compare_field("event_kind", want.kind, event_kind);
				compare_field("screen_x", want.sx, screen_x);
				compare_field("screen_y", want.sy, screen_y);
				compare_field("pressure", want.prs, pressure);
				compare_field("raw_x", want.rx, raw_x);
				compare_field("raw_y", want.ry, raw_y);
				compare_field("pen_active", want.act, pen_active);
				compare_field("pen_active_changed", want.chg, pen_active_changed);
				compare_field("idle_ms", want.idle, idle_ms);
				if (want.kind == KIND_PEN_DOWN || want.kind == KIND_ERASER_DOWN)
					downs_seen++;
				if (want.chg)
					edges_seen++;
			end
		end
	end

	// Watchdog: too long without a transfer on any channel means the block is hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((evt_valid && !evt_stall) || (res_valid && !res_stall)
					|| (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCH_LIMIT) begin
					$display("%0t: no transfer for %0d cycles, %0d reports still owed",
						$time, quiet_cycles, report_queue.size());
					$display("simulation failed");
					$finish;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		evt_valid = 1'b0;
		opcode = OP_KEY;
		event_code = '0;
		event_value = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_COEF_XX;
		cfg_data = '0;
		steady = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_holdoff();
		test_calibration_limits();
		test_backpressure();
		test_random_traffic();

		drain_reports();
		repeat (10) @(posedge clk);
		if (report_queue.size() != 0) begin
			errors++;
			$display("%0t: %0d reports never arrived", $time, report_queue.size());
		end

		$display("Covered %0d events and %0d result transfers: %0d strokes, %0d pen-active edges.",
			events_sent, results_seen, downs_seen, edges_seen);
		$display("Register writes: %0d over %0d calibration settings; %0d mismatches.",
			cfg_writes, settings_used, errors);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
